// ===== design/glbc_pkg.sv =====
// Shared types, constants and helpers for the grid line barrier check block.
package glbc_pkg;

  localparam int CW      = 10;           // grid index width
  localparam int SW      = CW + 1;       // signed coordinate difference
  localparam int PW      = CW + 2;       // signed sample position
  localparam int ACC_W   = 21;           // signed remainder accumulator
  localparam int WORD_W  = 64;           // map word width
  localparam int WSEL_W  = 6;            // bit select inside a word
  localparam int COLW_W  = CW - WSEL_W;  // word index along a row
  localparam int LINE_W  = 3;
  localparam int NUM_LINES = 5;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic MODE_WEAK   = 1'b0;
  localparam logic MODE_STRONG = 1'b1;

  localparam logic [LINE_W-1:0] LINE_MID  = 3'd0;
  localparam logic [LINE_W-1:0] LINE_LAST = 3'd4;

  localparam logic signed [ACC_W-1:0] K200 = 21'sd200;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_WB,
    ST_Q_SETUP,
    ST_L_LOAD,
    ST_L_NORM,
    ST_WALK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic              load;
    logic              norm;
    logic              adv;
    logic              half;
    logic [LINE_W-1:0] line;
  } smp_ctrl_t;

  typedef struct packed {
    logic signed [PW-1:0] cx;
    logic signed [PW-1:0] cy;
    logic                 neg_tie;
  } smp_pt_t;

  // Offset term (2*off + 100) in hundredths for the first axis.
  function automatic logic [7:0] off_x(input logic [LINE_W-1:0] line);
    logic [7:0] c;
    case (line)
      3'd0:    c = 8'd100;
      3'd1:    c = 8'd2;
      3'd2:    c = 8'd198;
      3'd3:    c = 8'd2;
      3'd4:    c = 8'd198;
      default: c = 8'd100;
    endcase
    return c;
  endfunction

  // Offset term (2*off + 100) in hundredths for the second axis.
  function automatic logic [7:0] off_y(input logic [LINE_W-1:0] line);
    logic [7:0] c;
    case (line)
      3'd0:    c = 8'd100;
      3'd1:    c = 8'd2;
      3'd2:    c = 8'd2;
      3'd3:    c = 8'd198;
      3'd4:    c = 8'd198;
      default: c = 8'd100;
    endcase
    return c;
  endfunction

endpackage

// ===== design/glbc_ifs.sv =====
// Channel interfaces of the grid line barrier check block.
interface glbc_in_if;
  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [glbc_pkg::CW-1:0]  cell_row;
  logic [glbc_pkg::CW-1:0]  cell_col;
  logic                     cell_is_barrier;
  logic [glbc_pkg::CW-1:0]  sink_x;
  logic [glbc_pkg::CW-1:0]  sink_y;
  logic [glbc_pkg::CW-1:0]  source_x;
  logic [glbc_pkg::CW-1:0]  source_y;
  modport source(output valid, command, cell_row, cell_col, cell_is_barrier,
                 sink_x, sink_y, source_x, source_y, input ready);
  modport sink(input valid, command, cell_row, cell_col, cell_is_barrier,
               sink_x, sink_y, source_x, source_y, output ready);
endinterface

interface glbc_out_if;
  logic valid;
  logic ready;
  logic blocked;
  modport source(output valid, blocked, input ready);
  modport sink(input valid, blocked, output ready);
endinterface

interface glbc_cfg_if;
  logic valid;
  logic ready;
  logic barrier_mode;
  modport source(output valid, barrier_mode, input ready);
  modport sink(input valid, barrier_mode, output ready);
endinterface

// ===== design/glbc_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module glbc_ram #(
  parameter int WIDTH  = 64,
  parameter int ADDR_W = 14
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/glbc_sampler.sv =====
// Sample point stepper: exact rational line position kept as cell plus remainder.
module glbc_sampler (
  input  logic                           clk,
  input  glbc_pkg::smp_ctrl_t            ctrl,
  input  logic [glbc_pkg::CW-1:0]        sink_x,
  input  logic [glbc_pkg::CW-1:0]        sink_y,
  input  logic signed [glbc_pkg::SW-1:0] dx,
  input  logic signed [glbc_pkg::SW-1:0] dy,
  input  logic [glbc_pkg::CW-1:0]        walk_len,
  output glbc_pkg::smp_pt_t              pt
);

  typedef struct packed {
    logic signed [glbc_pkg::PW-1:0]    pos;
    logic signed [glbc_pkg::ACC_W-1:0] rem;
  } fold_t;

  // Bring v into [0, m) with one correction; v lies in [-m, 2m).
  function automatic fold_t fold(input logic signed [glbc_pkg::PW-1:0] pos,
                                 input logic signed [glbc_pkg::ACC_W-1:0] v,
                                 input logic signed [glbc_pkg::ACC_W-1:0] m);
    fold_t r;
    if (v < 0) begin
      r.pos = pos - signed'(glbc_pkg::PW'(1));
      r.rem = v + m;
    end else if (v >= m) begin
      r.pos = pos + signed'(glbc_pkg::PW'(1));
      r.rem = v - m;
    end else begin
      r.pos = pos;
      r.rem = v;
    end
    return r;
  endfunction

  logic signed [glbc_pkg::ACC_W-1:0] mod_r, incx_r, incy_r, wx_r, wy_r;
  logic signed [glbc_pkg::ACC_W-1:0] remx_r, remy_r;
  logic signed [glbc_pkg::PW-1:0]    cx_r, cy_r;

  logic [glbc_pkg::CW:0]             dk;
  logic signed [glbc_pkg::ACC_W-1:0] dk_s, dx_s, dy_s, cx_s, cy_s, px, py;
  logic signed [glbc_pkg::PW-1:0]    sx_p, sy_p;
  fold_t                             fx_norm, fy_norm, fx_adv, fy_adv;

  always_comb begin
    dk   = ctrl.half ? {walk_len, 1'b0} : {1'b0, walk_len};
    dk_s = signed'(glbc_pkg::ACC_W'(dk));
    dx_s = glbc_pkg::ACC_W'(dx);
    dy_s = glbc_pkg::ACC_W'(dy);
    cx_s = signed'(glbc_pkg::ACC_W'(glbc_pkg::off_x(ctrl.line)));
    cy_s = signed'(glbc_pkg::ACC_W'(glbc_pkg::off_y(ctrl.line)));
    px   = dx_s * glbc_pkg::K200;
    py   = dy_s * glbc_pkg::K200;
    sx_p = signed'(glbc_pkg::PW'(sink_x));
    sy_p = signed'(glbc_pkg::PW'(sink_y));
    fx_norm = fold(sx_p, wx_r, mod_r);
    fy_norm = fold(sy_p, wy_r, mod_r);
    fx_adv  = fold(cx_r, remx_r + incx_r, mod_r);
    fy_adv  = fold(cy_r, remy_r + incy_r, mod_r);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mod_r  <= dk_s * glbc_pkg::K200;
      incx_r <= ctrl.half ? (px <<< 1) : px;
      incy_r <= ctrl.half ? (py <<< 1) : py;
      wx_r   <= dk_s * cx_s + px;
      wy_r   <= dk_s * cy_s + py;
    end
    if (ctrl.norm) begin
      cx_r   <= fx_norm.pos;
      remx_r <= fx_norm.rem;
      cy_r   <= fy_norm.pos;
      remy_r <= fy_norm.rem;
    end else if (ctrl.adv) begin
      cx_r   <= fx_adv.pos;
      remx_r <= fx_adv.rem;
      cy_r   <= fy_adv.pos;
      remy_r <= fy_adv.rem;
    end
  end

  // An exact tie at -0.5 rounds away from zero, out of the grid.
  assign pt.cx      = cx_r;
  assign pt.cy      = cy_r;
  assign pt.neg_tie = (cx_r == 0 && remx_r == 0) || (cy_r == 0 && remy_r == 0);

endmodule

// ===== design/grid_line_barrier_check.sv =====
// Top level of the grid line barrier check block: map memory, sequencer, handshakes.
// Write request: accepted from idle; the word is read, then the modified word is written back.
// Query request: a setup state, then per walked line a load and a normalise state and a walk
//   of at most D steps (one map read per step, D = Chebyshev distance), then the result goes
//   to the output register; up to five lines are walked, one request in work at a time.
// Reset: clear the map one word per cycle, 2**(clog2(min(GRID_SIZE,1024))+4) words.
module grid_line_barrier_check #(
  parameter int GRID_SIZE = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  glbc_in_if.sink     in_if,
  glbc_out_if.source  out_if,
  glbc_cfg_if.sink    cfg_if
);

  localparam int MAP_DIM = (GRID_SIZE < 1024) ? GRID_SIZE : 1024;
  localparam int XW      = $clog2(MAP_DIM);
  localparam int AW      = XW + glbc_pkg::COLW_W;
  localparam logic [glbc_pkg::CW:0] DIM_U = (glbc_pkg::CW + 1)'(MAP_DIM);
  localparam logic signed [glbc_pkg::PW-1:0] DIM_S = glbc_pkg::PW'(MAP_DIM);

  glbc_pkg::state_t state_r, state_nxt;

  logic                               mode_r;
  logic [AW-1:0]                      clr_addr_r, clr_addr_nxt;
  logic [AW-1:0]                      wr_addr_r, wr_addr_nxt;
  logic [glbc_pkg::WSEL_W-1:0]        wr_bit_r, wr_bit_nxt;
  logic                               wr_val_r, wr_val_nxt;
  logic [glbc_pkg::CW-1:0]            sx_r, sx_nxt, sy_r, sy_nxt;
  logic [glbc_pkg::CW-1:0]            tx_r, tx_nxt, ty_r, ty_nxt;
  logic signed [glbc_pkg::SW-1:0]     dx_r, dx_nxt, dy_r, dy_nxt;
  logic [glbc_pkg::CW-1:0]            dist_r, dist_nxt;
  logic [glbc_pkg::LINE_W-1:0]        line_r, line_nxt;
  logic [glbc_pkg::LINE_W-1:0]        hits_r, hits_nxt;
  logic [glbc_pkg::CW:0]              step_r, step_nxt;
  logic                               pend_r, pend_nxt;
  logic                               pend_oob_r, pend_oob_nxt;
  logic [glbc_pkg::WSEL_W-1:0]        pend_bit_r, pend_bit_nxt;
  logic                               res_r, res_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic                               blocked_r, blocked_nxt;

  // Memory and sampler controls
  logic                               mem_we;
  logic [AW-1:0]                      mem_waddr, mem_raddr;
  logic [glbc_pkg::WORD_W-1:0]        mem_wdata, mem_rdata, wr_word;
  glbc_pkg::smp_ctrl_t                smp_ctrl;
  glbc_pkg::smp_pt_t                  smp_pt;

  // Decoded request and walk terms
  logic                               in_acc, wr_in_range;
  logic [AW-1:0]                      in_addr, walk_addr;
  logic                               walk_oob, hit_now, more_steps;
  logic signed [glbc_pkg::SW-1:0]     dx_c, dy_c, ax_c, ay_c;
  logic [glbc_pkg::LINE_W-1:0]        hits_line;

  glbc_ram #(
    .WIDTH  (glbc_pkg::WORD_W),
    .ADDR_W (AW)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  glbc_sampler u_smp (
    .clk      (clk),
    .ctrl     (smp_ctrl),
    .sink_x   (sx_r),
    .sink_y   (sy_r),
    .dx       (dx_r),
    .dy       (dy_r),
    .walk_len (dist_r),
    .pt       (smp_pt)
  );

  assign cfg_if.ready   = 1'b1;
  assign out_if.valid   = out_valid_r;
  assign out_if.blocked = blocked_r;

  always_comb begin
    in_acc      = in_if.valid && in_if.ready;
    wr_in_range = ({1'b0, in_if.cell_row} < DIM_U) && ({1'b0, in_if.cell_col} < DIM_U);
    in_addr     = {in_if.cell_row[XW-1:0], in_if.cell_col[glbc_pkg::CW-1:glbc_pkg::WSEL_W]};
    walk_addr   = {smp_pt.cx[XW-1:0], smp_pt.cy[glbc_pkg::CW-1:glbc_pkg::WSEL_W]};
    walk_oob    = smp_pt.neg_tie || (smp_pt.cx < 0) || (smp_pt.cx >= DIM_S) ||
                  (smp_pt.cy < 0) || (smp_pt.cy >= DIM_S);
    hit_now     = pend_r && !pend_oob_r && mem_rdata[pend_bit_r];
    more_steps  = step_r <= {1'b0, dist_r};
    hits_line   = hits_r + glbc_pkg::LINE_W'(hit_now);
    dx_c        = signed'({1'b0, tx_r}) - signed'({1'b0, sx_r});
    dy_c        = signed'({1'b0, ty_r}) - signed'({1'b0, sy_r});
    ax_c        = (dx_c < 0) ? -dx_c : dx_c;
    ay_c        = (dy_c < 0) ? -dy_c : dy_c;
    wr_word     = mem_rdata;
    wr_word[wr_bit_r] = wr_val_r;
  end

  // Next state and datapath
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    wr_addr_nxt   = wr_addr_r;
    wr_bit_nxt    = wr_bit_r;
    wr_val_nxt    = wr_val_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    tx_nxt        = tx_r;
    ty_nxt        = ty_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    dist_nxt      = dist_r;
    line_nxt      = line_r;
    hits_nxt      = hits_r;
    step_nxt      = step_r;
    pend_nxt      = pend_r;
    pend_oob_nxt  = pend_oob_r;
    pend_bit_nxt  = pend_bit_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    blocked_nxt   = blocked_r;

    case (state_r)
      glbc_pkg::ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (&clr_addr_r) begin
          state_nxt = glbc_pkg::ST_IDLE;
        end
      end
      glbc_pkg::ST_IDLE: begin
        if (in_acc) begin
          wr_addr_nxt = in_addr;
          wr_bit_nxt  = in_if.cell_col[glbc_pkg::WSEL_W-1:0];
          wr_val_nxt  = in_if.cell_is_barrier;
          sx_nxt      = in_if.sink_x;
          sy_nxt      = in_if.sink_y;
          tx_nxt      = in_if.source_x;
          ty_nxt      = in_if.source_y;
          line_nxt    = glbc_pkg::LINE_MID;
          hits_nxt    = '0;
          if (in_if.command == glbc_pkg::CMD_QUERY) begin
            state_nxt = glbc_pkg::ST_Q_SETUP;
          end else if (wr_in_range) begin
            state_nxt = glbc_pkg::ST_WR_WB;
          end
        end
      end
      glbc_pkg::ST_WR_WB: begin
        state_nxt = glbc_pkg::ST_IDLE;
      end
      glbc_pkg::ST_Q_SETUP: begin
        dx_nxt   = dx_c;
        dy_nxt   = dy_c;
        dist_nxt = glbc_pkg::CW'((ax_c >= ay_c) ? ax_c : ay_c);
        if (dx_c == 0 && dy_c == 0) begin
          res_nxt   = 1'b0;
          state_nxt = glbc_pkg::ST_FINISH;
        end else begin
          state_nxt = glbc_pkg::ST_L_LOAD;
        end
      end
      glbc_pkg::ST_L_LOAD: begin
        state_nxt = glbc_pkg::ST_L_NORM;
      end
      glbc_pkg::ST_L_NORM: begin
        step_nxt  = (glbc_pkg::CW + 1)'(1);
        pend_nxt  = 1'b0;
        state_nxt = glbc_pkg::ST_WALK;
      end
      glbc_pkg::ST_WALK: begin
        if (hit_now || !more_steps) begin
          // Line settled: decide the query or move to the next line
          hits_nxt = hits_line;
          pend_nxt = 1'b0;
          if (mode_r == glbc_pkg::MODE_WEAK) begin
            if (!hit_now) begin
              res_nxt   = 1'b0;
              state_nxt = glbc_pkg::ST_FINISH;
            end else if (line_r == glbc_pkg::LINE_LAST) begin
              res_nxt   = 1'b1;
              state_nxt = glbc_pkg::ST_FINISH;
            end else begin
              line_nxt  = line_r + glbc_pkg::LINE_W'(1);
              state_nxt = glbc_pkg::ST_L_LOAD;
            end
          end else begin
            if (hits_line >= glbc_pkg::LINE_W'(2)) begin
              res_nxt   = 1'b1;
              state_nxt = glbc_pkg::ST_FINISH;
            end else if (line_r == glbc_pkg::LINE_LAST) begin
              res_nxt   = 1'b0;
              state_nxt = glbc_pkg::ST_FINISH;
            end else begin
              line_nxt  = line_r + glbc_pkg::LINE_W'(1);
              state_nxt = glbc_pkg::ST_L_LOAD;
            end
          end
        end else begin
          // Issue the read of the current sample, advance the stepper
          step_nxt     = step_r + (glbc_pkg::CW + 1)'(1);
          pend_nxt     = 1'b1;
          pend_oob_nxt = walk_oob;
          pend_bit_nxt = smp_pt.cy[glbc_pkg::WSEL_W-1:0];
        end
      end
      glbc_pkg::ST_FINISH: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          blocked_nxt   = res_r;
          state_nxt     = glbc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = glbc_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_if.ready   = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = wr_addr_r;
    mem_wdata     = wr_word;
    mem_raddr     = walk_addr;
    smp_ctrl      = '0;
    smp_ctrl.line = line_r;
    smp_ctrl.half = (mode_r == glbc_pkg::MODE_STRONG) && (line_r != glbc_pkg::LINE_MID);

    case (state_r)
      glbc_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = '0;
      end
      glbc_pkg::ST_IDLE: begin
        in_if.ready = 1'b1;
        mem_raddr   = in_addr;
      end
      glbc_pkg::ST_WR_WB: begin
        mem_we = 1'b1;
      end
      glbc_pkg::ST_L_LOAD: begin
        smp_ctrl.load = 1'b1;
      end
      glbc_pkg::ST_L_NORM: begin
        smp_ctrl.norm = 1'b1;
      end
      glbc_pkg::ST_WALK: begin
        smp_ctrl.adv = !hit_now && more_steps;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= glbc_pkg::ST_CLEAR;
      mode_r      <= glbc_pkg::MODE_WEAK;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      line_r      <= '0;
      hits_r      <= '0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      line_r      <= line_nxt;
      hits_r      <= hits_nxt;
      step_r      <= step_nxt;
      if (cfg_if.valid && cfg_if.ready) begin
        mode_r <= cfg_if.barrier_mode;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    wr_addr_r  <= wr_addr_nxt;
    wr_bit_r   <= wr_bit_nxt;
    wr_val_r   <= wr_val_nxt;
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    tx_r       <= tx_nxt;
    ty_r       <= ty_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    dist_r     <= dist_nxt;
    pend_oob_r <= pend_oob_nxt;
    pend_bit_r <= pend_bit_nxt;
    res_r      <= res_nxt;
    blocked_r  <= blocked_nxt;
  end

  // Map writes happen only in the clearing pass or a write-back
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == glbc_pkg::ST_CLEAR || state_r == glbc_pkg::ST_WR_WB))
    else $error("map write outside clear or write-back");

  // Each walked line adds at most one hit
  a_hits_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == glbc_pkg::ST_WALK) |-> (hits_r <= line_r))
    else $error("hit count exceeds walked lines");

  // The walk never issues past the last step
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == glbc_pkg::ST_WALK) |-> (step_r <= {1'b0, dist_r} + (glbc_pkg::CW + 1)'(1)))
    else $error("walk step beyond distance");

  // A new result is loaded only from the finish state
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r || out_if.ready) && out_valid_nxt |-> (state_r == glbc_pkg::ST_FINISH))
    else $error("result loaded outside finish");

endmodule

// ===== bench/tb_glbc_scoreboard.sv =====
// Blocked-flag predictor and result scoreboard for the grid line barrier check.
`timescale 1ns / 1ps
class glbc_scoreboard;
  bit barrier_cells [1024][1024];
  bit strong_mode;
  bit pending_flags [$];
  int mismatches;

  function void clear_map();
    foreach (barrier_cells[r, c]) barrier_cells[r][c] = 1'b0;
  endfunction

  static function longint round_half_away(longint n, longint m);
    if (n >= 0) return (2 * n + m) / (2 * m);
    return -((-2 * n + m) / (2 * m));
  endfunction

  function bit sample_cell(longint x, longint y);
    if (x < 0 || y < 0 || x > 1023 || y > 1023) return 1'b0;
    return barrier_cells[x][y];
  endfunction

  // Walk one sampled line; offsets are in hundredths of a cell.
  function bit walk_line(longint sx, longint sy, longint dx, longint dy, longint steps,
                         longint ox, longint oy, bit half_steps);
    longint k, m, t, nx, ny;
    k = half_steps ? 2 : 1;
    m = 100 * k * steps;
    for (longint i = 1; i <= steps; i++) begin
      t = half_steps ? (2 * i - 1) : i;
      nx = m * sx + k * ox * steps + 100 * t * dx;
      ny = m * sy + k * oy * steps + 100 * t * dy;
      if (sample_cell(round_half_away(nx, m), round_half_away(ny, m))) return 1'b1;
    end
    return 1'b0;
  endfunction

  function bit predict_blocked(int sx, int sy, int tx, int ty);
    longint dx, dy, span_len;
    longint offx [4];
    longint offy [4];
    int hits;
    offx = '{-49, 49, -49, 49};
    offy = '{-49, -49, 49, 49};
    dx = tx - sx;
    dy = ty - sy;
    span_len = (dx < 0 ? -dx : dx) >= (dy < 0 ? -dy : dy) ? (dx < 0 ? -dx : dx)
                                                          : (dy < 0 ? -dy : dy);
    if (span_len == 0) return 1'b0;
    hits = walk_line(sx, sy, dx, dy, span_len, 0, 0, 1'b0);
    for (int j = 0; j < 4; j++) begin
      if (!strong_mode && hits == j + 1)
        hits += walk_line(sx, sy, dx, dy, span_len, offx[j], offy[j], 1'b0);
      else if (strong_mode && hits < 2)
        hits += walk_line(sx, sy, dx, dy, span_len, offx[j], offy[j], 1'b1);
    end
    return strong_mode ? (hits >= 2) : (hits == 5);
  endfunction

  // Fields reach the block as 10-bit values; fold the noted request the same way.
  function void note_request(bit cmd, int row, int col, bit bar, int sx, int sy,
                             int tx, int ty);
    int r, c;
    r = row & 1023;
    c = col & 1023;
    if (cmd == glbc_pkg::CMD_WRITE) barrier_cells[r][c] = bar;
    else pending_flags.push_back(predict_blocked(sx & 1023, sy & 1023, tx & 1023,
                                                 ty & 1023));
  endfunction

  function void check_result(bit actual);
    bit want;
    if (pending_flags.size() == 0) begin
      $display("%0t: unexpected result blocked=%0b", $time, actual);
      mismatches++;
      return;
    end
    want = pending_flags.pop_front();
    if (want !== actual) begin
      $display("%0t: blocked mismatch expected=%0b actual=%0b", $time, want, actual);
      mismatches++;
    end
  endfunction
endclass

// ===== bench/tb_top.sv =====
// Top-level testbench: drives requests, configuration and result stalls of the block.
`timescale 1ns / 1ps
module tb_top;

  logic clk;
  logic rst_n;
  glbc_in_if  in_if();
  glbc_out_if out_if();
  glbc_cfg_if cfg_if();

  grid_line_barrier_check uut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if.sink), .out_if(out_if.source),
    .cfg_if(cfg_if.sink)
  );

  glbc_scoreboard board;
  bit long_holdoff;   // raised to make the receiver stall for a long stretch
  bit drain_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous fixed limit: reset clear pass plus worst-case walks and stalls.
  initial begin
    #200ms;
    $display("end of test: mismatches");
    $finish;
  end

  // Offer one request and hold it until the handshake completes; valid stays high
  // for a back-to-back request and drops only across a gap or a drain.
  task automatic send_request(bit cmd, int row, int col, bit bar, int sx, int sy,
                              int tx, int ty, int gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.command <= cmd;
    in_if.cell_row <= row[9:0];
    in_if.cell_col <= col[9:0];
    in_if.cell_is_barrier <= bar;
    in_if.sink_x <= sx[9:0];
    in_if.sink_y <= sy[9:0];
    in_if.source_x <= tx[9:0];
    in_if.source_y <= ty[9:0];
    do @(posedge clk); while (!in_if.ready);
    board.note_request(cmd, row, col, bar, sx, sy, tx, ty);
  endtask

  task automatic write_cell(int row, int col, bit bar);
    send_request(glbc_pkg::CMD_WRITE, row, col, bar, $urandom_range(1023),
                 $urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
                 $urandom_range(13));
  endtask

  task automatic query_path(int sx, int sy, int tx, int ty);
    send_request(glbc_pkg::CMD_QUERY, $urandom_range(1023), $urandom_range(1023),
                 $urandom_range(1), sx, sy, tx, ty, $urandom_range(13));
  endtask

  // Drop valid, wait for every expected result, then let a trailing write finish.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (board.pending_flags.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_mode(bit mode);
    cfg_if.valid <= 1'b1;
    cfg_if.barrier_mode <= mode;
    do @(posedge clk); while (!cfg_if.ready);
    board.strong_mode = mode;
    cfg_if.valid <= 1'b0;
  endtask

  // Random query, mostly near a cluster so walks stay short and meet barriers often.
  task automatic random_query(int cx, int cy);
    int span;
    span = ($urandom_range(19) == 0) ? 1023 : 12;
    query_path(cx + $urandom_range(span) - span / 2, cy + $urandom_range(span) - span / 2,
               cx + $urandom_range(span) - span / 2, cy + $urandom_range(span) - span / 2);
  endtask

  // Result side: random stalls, with a long hold-off on request.
  initial begin
    out_if.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (long_holdoff) begin
        out_if.ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_holdoff = 1'b0;
      end
      out_if.ready <= ($urandom_range(3) != 0) ? 1'b1 : 1'b0;
      @(posedge clk);
      if (out_if.valid && out_if.ready) board.check_result(out_if.blocked);
      if (!out_if.ready && $urandom_range(2) == 0) repeat ($urandom_range(13)) @(posedge clk);
    end
  end

  initial begin
    int cx, cy;
    board = new();
    board.clear_map();
    rst_n = 1'b0;
    in_if.valid = 1'b0; in_if.command = glbc_pkg::CMD_WRITE; in_if.cell_row = '0;
    in_if.cell_col = '0; in_if.cell_is_barrier = 1'b0; in_if.sink_x = '0;
    in_if.sink_y = '0; in_if.source_x = '0; in_if.source_y = '0;
    cfg_if.valid = 1'b0; cfg_if.barrier_mode = glbc_pkg::MODE_WEAK;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero distance, corners, a wall across a short path, edge of grid.
    query_path(5, 5, 5, 5);
    query_path(0, 0, 1023, 1023);
    for (int r = 8; r <= 12; r++) write_cell(r, 10, 1'b1);
    write_cell(1023, 1023, 1'b1);
    write_cell(1023, 0, 1'b1);
    query_path(10, 5, 10, 15);
    query_path(10, 15, 10, 5);
    query_path(1023, 1020, 1023, 1023);
    query_path(0, 1023, 1023, 0);
    drain();
    set_mode(glbc_pkg::MODE_STRONG);
    query_path(10, 5, 10, 15);
    query_path(12, 8, 6, 14);
    query_path(1022, 1022, 1023, 1023);
    write_cell(10, 10, 1'b0);
    query_path(10, 5, 10, 15);
    query_path(3, 3, 3, 3);
    drain();
    set_mode(glbc_pkg::MODE_WEAK);

    // Random phases over both modes; the receiver stalls long in the second.
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 1) long_holdoff = 1'b1;
      for (int n = 0; n < 52; n++) begin
        cx = $urandom_range(1023);
        cy = $urandom_range(1023);
        if (n % 5 == 0) begin
          // Build a short random wall then probe across it.
          for (int w = 0; w < 4; w++)
            write_cell(cx + w - 2, cy + $urandom_range(2), $urandom_range(5) != 0);
          random_query(cx, cy);
          random_query(cx, cy);
        end else if ($urandom_range(3) == 0) begin
          write_cell($urandom_range(1023), $urandom_range(1023), $urandom_range(1));
        end else begin
          random_query(cx, cy);
        end
      end
      drain();
      set_mode(phase % 2 == 0);
    end
    drain();
    repeat (100) @(posedge clk);
    if (board.mismatches == 0 && board.pending_flags.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule

// ===== files.f =====
design/glbc_pkg.sv
design/glbc_ifs.sv
design/glbc_ram.sv
design/glbc_sampler.sv
design/grid_line_barrier_check.sv
bench/tb_glbc_scoreboard.sv
bench/tb_top.sv
